@@ design/gdls_pkg.sv @@
// Shared types and constants for the genotype decode / location standardise block.
// No dependencies; the front end, back end and top level use it by scoped name.
`timescale 1ns / 1ps

package gdls_pkg;

  localparam int FRAC_BITS = 16;   // fraction bits of the per-location dosage sums
  localparam int LOC_W     = 9;
  localparam int FREQ_W    = 16;
  localparam int SUM_W     = 30;
  localparam int STD_W     = 24;
  localparam int MISS_W    = 32;

  localparam logic [SUM_W-1:0] SUM_MAX     = '1;
  localparam logic [STD_W-1:0] STD_POS_MAX = 24'h7F_FFFF;
  localparam logic [STD_W-1:0] STD_NEG_MAG = 24'h80_0000;

  typedef enum logic {
    MODE_ACC  = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CODE_HOM_REF = 2'd0,
    CODE_MISSING = 2'd1,
    CODE_HET     = 2'd2,
    CODE_HOM_ALT = 2'd3
  } geno_code_t;

  typedef struct packed {
    mode_t             mode;
    geno_code_t        code;
    logic [LOC_W-1:0]  location;
    logic [FREQ_W-1:0] allele_freq;
  } in_item_t;

  typedef struct packed {
    logic [LOC_W-1:0]        out_location;
    logic signed [STD_W-1:0] std_dosage;
    logic                    empty_res;
    logic [MISS_W-1:0]       missing_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CLEAR,
    ST_MEAN,
    ST_ROOT,
    ST_QUOT,
    ST_OUT
  } back_state_t;

endpackage

@@ design/gdls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gdls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/gdls_div.sv @@
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module gdls_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW-1:0]    rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    ge       = trial >= {1'b0, den_r};
    rem_next = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // numerator bits shift out of the top while quotient bits shift in below;
  // the divisor is held for the whole pass
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      cnt   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= rem_next;
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

@@ design/gdls_isqrt.sv @@
// Integer square root, digit by digit, one result bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module gdls_isqrt #(
  parameter int W = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     val,
  output logic             busy,
  output logic [W/2-1:0]   root
);

  localparam int RW    = W / 2;
  localparam int CNT_W = $clog2(RW);

  logic [W-1:0]     v_sh;
  logic [RW+1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic             ge;

  always_comb begin
    rem_sh = {rem[RW-1:0], v_sh[W-1:W-2]};
    trial  = {root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(RW - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_sh <= val;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      v_sh <= {v_sh[W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[RW-2:0], ge};
      cnt  <= cnt + CNT_W'(1);
    end
  end

endmodule

@@ design/gdls_front.sv @@
// Front end: drops beats for unmapped locations and queues the rest (two entries).
// Depends on gdls_pkg.
`timescale 1ns / 1ps

module gdls_front #(
  parameter int NUM_LOCATIONS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  gdls_pkg::in_item_t sample,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output gdls_pkg::in_item_t cmd
);

  gdls_pkg::in_item_t slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic               loc_ok;
  logic               push;
  logic               pop;

  always_comb begin
    loc_ok = (sample.location != '0) &&
             (17'(sample.location) <= 17'(NUM_LOCATIONS));
    sample_ready = fill != 2'd2;
    push      = sample_valid && sample_ready && loc_ok;
    cmd_valid = fill != 2'd0;
    pop       = cmd_valid && cmd_ready;
    cmd       = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= sample;
    end
  end

endmodule

@@ design/gdls_back.sv @@
// Back end: per-location accumulation in RAM and the readout arithmetic.
// Depends on gdls_pkg, gdls_ram, gdls_div and gdls_isqrt.
`timescale 1ns / 1ps

module gdls_back #(
  parameter int NUM_LOCATIONS            = 256,
  parameter int MAX_SAMPLES_PER_LOCATION = 4095
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  gdls_pkg::in_item_t  cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output gdls_pkg::out_item_t res
);

  localparam int AW     = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
  localparam int CW     = $clog2(MAX_SAMPLES_PER_LOCATION + 1);
  localparam int SW     = gdls_pkg::SUM_W;
  localparam int EW     = SW + CW;
  localparam int NW     = 64;
  localparam int DW     = 32;
  localparam int MISS_W = gdls_pkg::MISS_W;
  localparam int STD_W  = gdls_pkg::STD_W;
  localparam int FB     = gdls_pkg::FRAC_BITS;
  localparam int MW     = 17 + FB;

  gdls_pkg::back_state_t state, state_next;

  gdls_pkg::in_item_t     cur;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          cmd_idx;
  logic                   hit;
  logic [NUM_LOCATIONS-1:0] filled;
  logic [MISS_W-1:0]      missing;
  logic [NW-1:0]          mag;
  logic                   neg;
  logic [STD_W-1:0]       std_r;
  logic                   empty_r;

  logic          ram_wr_en;
  logic          ram_rd_en;
  logic [EW-1:0] ram_wr_data;
  logic [EW-1:0] ram_rd_data;

  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;

  logic          sq_start;
  logic [NW-1:0] sq_val;
  logic          sq_busy;
  logic [DW-1:0] sq_root;

  logic [SW-1:0] rd_sum;
  logic [CW-1:0] rd_cnt;
  logic          full;
  logic          has_samples;
  logic [MW-1:0] miss_wide;
  logic [SW:0]   dose;
  logic [SW:0]   sum_add;
  logic [SW-1:0] sum_new;
  logic [NW-1:0] two_f;
  logic [33:0]   var_prod;
  logic          out_load;

  function automatic logic [STD_W-1:0] sat_std(input logic n, input logic [NW-1:0] q);
    logic [STD_W-1:0] m;
    if (n) begin
      m = (q > NW'(gdls_pkg::STD_NEG_MAG)) ? gdls_pkg::STD_NEG_MAG : q[STD_W-1:0];
      return STD_W'(0) - m;
    end
    return (q > NW'(gdls_pkg::STD_POS_MAX)) ? gdls_pkg::STD_POS_MAX : q[STD_W-1:0];
  endfunction

  gdls_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LOCATIONS)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (cmd_idx),
    .rd_data (ram_rd_data)
  );

  gdls_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  gdls_isqrt #(
    .W (NW)
  ) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   (sq_val),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  // datapath
  always_comb begin
    cmd_idx     = AW'(cmd.location - gdls_pkg::LOC_W'(1));
    rd_sum      = hit ? ram_rd_data[EW-1:CW] : '0;
    rd_cnt      = hit ? ram_rd_data[CW-1:0] : '0;
    full        = rd_cnt >= CW'(MAX_SAMPLES_PER_LOCATION);
    has_samples = rd_cnt != '0;
    miss_wide   = MW'({cur.allele_freq, 1'b0}) << FB;
    case (cur.code)
      gdls_pkg::CODE_HOM_REF: dose = (SW + 1)'(2) << FB;
      gdls_pkg::CODE_HET:     dose = (SW + 1)'(1) << FB;
      gdls_pkg::CODE_HOM_ALT: dose = '0;
      default:                dose = (SW + 1)'(miss_wide >> 16);
    endcase
    sum_add     = {1'b0, rd_sum} + dose;
    sum_new     = sum_add[SW] ? gdls_pkg::SUM_MAX : sum_add[SW-1:0];
    ram_wr_data = {sum_new, CW'(rd_cnt + CW'(1))};
    two_f       = NW'({cur.allele_freq, 1'b0}) << 16;
    // 2f(1-f) in Q0.32, at most 2^31
    var_prod    = 34'({1'b0, cur.allele_freq, 1'b0}) *
                  34'(17'h1_0000 - {1'b0, cur.allele_freq});
    sq_val      = {var_prod[31:0], 32'b0};
    if (state == gdls_pkg::ST_CLEAR) begin
      div_num = NW'(rd_sum) << (32 - FB);
      div_den = DW'(rd_cnt);
    end else begin
      div_num = mag << 16;
      div_den = sq_root;
    end
    out_load = !res_valid || res_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gdls_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.mode == gdls_pkg::MODE_READ) ? gdls_pkg::ST_CLEAR
                                                         : gdls_pkg::ST_ACC;
        end
      end
      gdls_pkg::ST_ACC: state_next = gdls_pkg::ST_IDLE;
      gdls_pkg::ST_CLEAR: begin
        state_next = has_samples ? gdls_pkg::ST_MEAN : gdls_pkg::ST_OUT;
      end
      gdls_pkg::ST_MEAN: begin
        if (div_done) begin
          state_next = gdls_pkg::ST_ROOT;
        end
      end
      gdls_pkg::ST_ROOT: begin
        if (!sq_busy) begin
          state_next = (mag == '0 || sq_root == '0) ? gdls_pkg::ST_OUT : gdls_pkg::ST_QUOT;
        end
      end
      gdls_pkg::ST_QUOT: begin
        if (div_done) begin
          state_next = gdls_pkg::ST_OUT;
        end
      end
      gdls_pkg::ST_OUT: begin
        if (out_load) begin
          state_next = gdls_pkg::ST_IDLE;
        end
      end
      default: state_next = gdls_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready = 1'b0;
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;
    unique case (state)
      gdls_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        ram_rd_en = cmd_valid;
      end
      gdls_pkg::ST_ACC:   ram_wr_en = !full;
      gdls_pkg::ST_CLEAR: begin
        div_start = has_samples;
        sq_start  = has_samples;
      end
      gdls_pkg::ST_ROOT:  div_start = !sq_busy && mag != '0 && sq_root != '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdls_pkg::ST_IDLE;
      filled    <= '0;
      missing   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gdls_pkg::ST_ACC) begin
        if (cur.code == gdls_pkg::CODE_MISSING) begin
          missing <= missing + MISS_W'(1);
        end
        if (!full) begin
          filled[idx] <= 1'b1;
        end
      end
      // a cleared location reads back as zero until written again
      if (state == gdls_pkg::ST_CLEAR) begin
        filled[idx] <= 1'b0;
      end
      if (state == gdls_pkg::ST_OUT && out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == gdls_pkg::ST_IDLE && cmd_valid) begin
      cur <= cmd;
      idx <= cmd_idx;
      hit <= filled[cmd_idx];
    end
    if (state == gdls_pkg::ST_CLEAR) begin
      std_r   <= '0;
      empty_r <= !has_samples;
    end
    if (state == gdls_pkg::ST_MEAN && div_done) begin
      neg <= div_quo < two_f;
      mag <= (div_quo < two_f) ? (two_f - div_quo) : (div_quo - two_f);
    end
    if (state == gdls_pkg::ST_ROOT && !sq_busy && mag != '0 && sq_root == '0) begin
      std_r <= sat_std(neg, NW'(gdls_pkg::STD_NEG_MAG));
    end
    if (state == gdls_pkg::ST_QUOT && div_done) begin
      std_r <= sat_std(neg, div_quo);
    end
    if (state == gdls_pkg::ST_OUT && out_load) begin
      res.out_location  <= cur.location;
      res.std_dosage    <= $signed(std_r);
      res.empty_res     <= empty_r;
      res.missing_total <= missing;
    end
  end

endmodule

@@ design/genotype_decode_location_standardize.sv @@
// Top level of the genotype decode / per-location standardise block.
// Depends on gdls_pkg, gdls_front and gdls_back.
`timescale 1ns / 1ps

// Each sample beat carries a 2-bit genotype code, a location and the SNP's
// allele frequency (Q0.16). Mode 0 adds the decoded dosage (2, 1, 0, or 2*freq
// for a missing code) to the location's sum in RAM and counts the sample;
// mode 1 returns (mean - 2*freq) / sqrt(2*freq*(1-freq)) as saturated Q8.16
// and clears the location. Beats for location 0 or beyond NUM_LOCATIONS are
// dropped in the front end and give no result. A two-entry queue sits
// between the front end and the sequencer, so up to two samples are still
// taken while a readout is computed or a result waits on the result port.
// Sequence: an accumulate beat passes the idle state (RAM read), then the
// accumulate state (read-modify-write). A readout makes two passes through
// the shared bit-serial divider, mean then final quotient; the square root
// runs alongside the first pass. An empty location skips the arithmetic and
// goes from the clear state straight to output. No clearing pass is needed
// after reset: per-location valid flags make untouched entries read as zero.

module genotype_decode_location_standardize #(
  parameter int NUM_LOCATIONS            = 256,
  parameter int MAX_SAMPLES_PER_LOCATION = 4095
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  gdls_pkg::in_item_t  sample,
  output logic                result_valid,
  input  logic                result_ready,
  output gdls_pkg::out_item_t result
);

  // queued beats, already filtered for a usable location
  logic               cmd_valid;
  logic               cmd_ready;
  gdls_pkg::in_item_t cmd;

  gdls_front #(
    .NUM_LOCATIONS (NUM_LOCATIONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // sequencer, accumulation RAM, divider and root unit, result register
  gdls_back #(
    .NUM_LOCATIONS            (NUM_LOCATIONS),
    .MAX_SAMPLES_PER_LOCATION (MAX_SAMPLES_PER_LOCATION)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (result_valid),
    .res_ready (result_ready),
    .res       (result)
  );

endmodule
